FILE: src/alc_pkg.sv
// shared types and constants for the active lane consolidation permute
package alc_pkg;

    localparam int LANES  = 4;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = $clog2(LANES);
    localparam int CNT_W  = $clog2(LANES + 1);
    // a_lane*, b_lane*, a_mask, b_mask packed without gaps (whole bytes for four lanes)
    localparam int ITEM_W = 2 * LANES * VAL_W + 2 * LANES;

    typedef logic signed [VAL_W-1:0] lane_t;
    typedef lane_t [LANES-1:0]       lane_vec_t;
    typedef logic [LANES-1:0]        mask_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    // input item, first field in the highest bits
    typedef struct packed {
        mask_t     b_mask;
        mask_t     a_mask;
        lane_vec_t b_lanes;
        lane_vec_t a_lanes;
    } in_item_t;

    // result item, first field in the highest bits
    typedef struct packed {
        mask_t     rest_mask;
        mask_t     packed_mask;
        lane_vec_t rest_lanes;
        lane_vec_t packed_lanes;
    } out_item_t;

    // stable partition of one vector: active lanes first, then inactive lanes
    typedef struct packed {
        lane_vec_t lanes;
        cnt_t      cnt;
    } part_t;

endpackage

FILE: src/alc_partition.sv
// stable partition of one vector by its lane mask, with active lane count
module alc_partition (
    input  alc_pkg::lane_vec_t lanes,
    input  alc_pkg::mask_t     mask,
    output alc_pkg::part_t     part
);
    import alc_pkg::*;

    logic [IDX_W-1:0] pos [LANES];
    cnt_t             total;
    cnt_t             n_act;
    cnt_t             n_ina;
    lane_vec_t        sorted;

    // active lane count
    always_comb
    begin
        total = '0;
        for (int j = 0; j < LANES; j++)
        begin
            total = total + CNT_W'(mask[j]);
        end
    end

    // destination slot of each source lane
    always_comb
    begin
        n_act = '0;
        n_ina = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (mask[j])
            begin
                pos[j] = n_act[IDX_W-1:0];
                n_act  = n_act + cnt_t'(1);
            end
            else
            begin
                pos[j] = IDX_W'(total + n_ina);
                n_ina  = n_ina + cnt_t'(1);
            end
        end
    end

    // scatter lanes to their slots, slots form a permutation
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sorted[k] = '0;
            for (int j = 0; j < LANES; j++)
            begin
                if (pos[j] == IDX_W'(k))
                begin
                    sorted[k] = sorted[k] | lanes[j];
                end
            end
        end
    end

    assign part.lanes = sorted;
    assign part.cnt   = total;

endmodule

FILE: src/alc_merge.sv
// merges the two partitions into the packed and rest vectors with their masks
module alc_merge (
    input  alc_pkg::part_t     part_a,
    input  alc_pkg::part_t     part_b,
    output alc_pkg::out_item_t result
);
    import alc_pkg::*;

    logic [CNT_W:0] sum_cnt;
    cnt_t           free_slots;
    cnt_t           idx_b;
    cnt_t           idx_a;

    assign sum_cnt    = {1'b0, part_a.cnt} + {1'b0, part_b.cnt};
    assign free_slots = CNT_W'(LANES) - part_a.cnt;

    // lane selection and masks
    always_comb
    begin
        idx_b = '0;
        idx_a = '0;
        for (int i = 0; i < LANES; i++)
        begin
            // packed: active A, then partition of B shifted up by countA
            idx_b = CNT_W'(i) - part_a.cnt;
            if (CNT_W'(i) < part_a.cnt)
            begin
                result.packed_lanes[i] = part_a.lanes[i];
            end
            else
            begin
                result.packed_lanes[i] = part_b.lanes[idx_b[IDX_W-1:0]];
            end

            // rest: inactive A packed low, partition of B in place above
            idx_a = CNT_W'(i) + part_a.cnt;
            if (CNT_W'(i) < free_slots)
            begin
                result.rest_lanes[i] = part_a.lanes[idx_a[IDX_W-1:0]];
            end
            else
            begin
                result.rest_lanes[i] = part_b.lanes[i];
            end

            result.packed_mask[i] = ((CNT_W+1)'(i) < sum_cnt);
            result.rest_mask[i]   = (CNT_W'(i) >= free_slots) && (CNT_W'(i) < part_b.cnt);
        end
    end

endmodule

FILE: src/active_lane_consolidation_permute.sv
// top level: input register, partition and merge logic, result register
//
//  channel  | direction | bits | contents
//  s_axis   | in        | 264  | a_lane0..3, b_lane0..3, a_mask, b_mask
//  m_axis   | out       | 264  | packed_lane0..3, rest_lane0..3, packed_mask, rest_mask
//
// one item per cycle sustained while m_axis_tready stays high; a result passes through the
// input register, then the result register behind the partition and merge logic
// rst_n clears both valid flags at once; payload registers are not reset
// while the result waits, the input register still takes one item; then
// s_axis_tready follows m_axis_tready
module active_lane_consolidation_permute (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // a_lane0, a_lane1, a_lane2, a_lane3, b_lane0, b_lane1, b_lane2, b_lane3, a_mask, b_mask
    input  logic [alc_pkg::ITEM_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // packed_lane0..3, rest_lane0..3, packed_mask, rest_mask
    output logic [alc_pkg::ITEM_W-1:0]  m_axis_tdata
);
    import alc_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    part_t     part_a;
    part_t     part_b;
    out_item_t result;

    // handshake
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item_t'(s_axis_tdata);
        end
    end

    // partition of each vector
    alc_partition u_part_a (
        .lanes (in_item_reg.a_lanes),
        .mask  (in_item_reg.a_mask),
        .part  (part_a)
    );

    alc_partition u_part_b (
        .lanes (in_item_reg.b_lanes),
        .mask  (in_item_reg.b_mask),
        .part  (part_b)
    );

    alc_merge u_merge (
        .part_a (part_a),
        .part_b (part_b),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_item_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = ITEM_W'(out_item_reg);

    // packed mask is a run of ones from lane 0
    a_packed_mask_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_item_reg.packed_mask & (out_item_reg.packed_mask + mask_t'(1)))
                           == '0))
        else $error("packed mask not contiguous from lane 0");

    // leftover lanes exist only when the packed vector is full
    a_rest_implies_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.rest_mask != '0)) |-> (&out_item_reg.packed_mask))
        else $error("rest mask set while packed vector not full");

    // a held item moves to the result register when the slot is free
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> out_valid_reg)
        else $error("item lost between input and result register");

    // an accepted item always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted transfer not held");

endmodule
